[hdl/dedup_fifo_queue_macros.svh]
// Assertion macros shared by the dedup FIFO queue RTL.
`ifndef DEDUP_FIFO_QUEUE_MACROS_SVH
`define DEDUP_FIFO_QUEUE_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset
`define DFQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be true outside reset
`define DFQ_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DFQ_ASSERT(lbl, prop, msg)
`define DFQ_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

[hdl/dfq_pkg.sv]
// Shared types and constants for the dedup FIFO queue.
`timescale 1ns / 1ps
package dfq_pkg;

    // Default geometry
    localparam int DEPTH_DEFAULT   = 16;
    localparam int ID_BITS_DEFAULT = 32;

    // Capacity register
    localparam int               CAP_BITS  = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    // Operation codes (code three is ignored)
    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_LOOKUP = 2'd2
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_DUP   = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

endpackage

[hdl/dedup_fifo_queue.sv]
// Top level of the dedup FIFO queue: sequencer plus identifier storage.
`timescale 1ns / 1ps
// Bounded FIFO of call identifiers that refuses duplicates. Operations: push
// (status full once occupancy reaches capacity_limit, clamped to DEPTH; else
// duplicate if queued; else appended), pop (oldest identifier or empty) and
// lookup (found flag). One operation is in flight at a time. A push or lookup
// scans the stored entries from the head, at most entry_count (DEPTH worst
// case; the scan stops early at the first matching entry), then finishes; a
// pop reads the head entry, then finishes; a full push, empty pop or unused
// operation code finishes at once. The scan length is set by the single read
// port of the identifier memory, which returns one stored entry per cycle. A
// finished result sits in an output register, so a stalled result channel only
// holds the block once the next result is ready. cfg_ready is always high;
// write capacity_limit only while the block is idle.
module dedup_fifo_queue
    import dfq_pkg::*;
#(
    parameter int DEPTH   = DEPTH_DEFAULT,
    parameter int ID_BITS = ID_BITS_DEFAULT,
    localparam int ADDR_BITS = $clog2(DEPTH),
    localparam int CNT_BITS  = $clog2(DEPTH + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          operation,
    input  logic [ID_BITS-1:0]  call_id,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic                found,
    output logic [ID_BITS-1:0]  popped_id,
    output logic [CNT_BITS-1:0] occupancy,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CAP_BITS-1:0] cfg_data
);

    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [ID_BITS-1:0]   wr_data;
    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_addr;
    logic [ID_BITS-1:0]   rd_data;

    // Sequencer
    dfq_ctrl #(
        .DEPTH   (DEPTH),
        .ID_BITS (ID_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .call_id   (call_id),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .found     (found),
        .popped_id (popped_id),
        .occupancy (occupancy),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    // Identifier ring
    dfq_store #(
        .DEPTH   (DEPTH),
        .ID_BITS (ID_BITS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

[hdl/dfq_store.sv]
// Identifier ring storage: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module dfq_store
    import dfq_pkg::*;
#(
    parameter int DEPTH   = DEPTH_DEFAULT,
    parameter int ID_BITS = ID_BITS_DEFAULT,
    localparam int ADDR_BITS = $clog2(DEPTH)
)
(
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [ID_BITS-1:0]   wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [ID_BITS-1:0]   rd_data
);

    logic [ID_BITS-1:0] mem [DEPTH];

    // Synchronous write and read; read data holds between reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hdl/dfq_ctrl.sv]
// Queue sequencer: ring pointers, duplicate scan, result register and capacity.
`timescale 1ns / 1ps
`include "dedup_fifo_queue_macros.svh"
module dfq_ctrl
    import dfq_pkg::*;
#(
    parameter int DEPTH   = DEPTH_DEFAULT,
    parameter int ID_BITS = ID_BITS_DEFAULT,
    localparam int ADDR_BITS = $clog2(DEPTH),
    localparam int CNT_BITS  = $clog2(DEPTH + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           operation,
    input  logic [ID_BITS-1:0]   call_id,
    // result channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic                 found,
    output logic [ID_BITS-1:0]   popped_id,
    output logic [CNT_BITS-1:0]  occupancy,
    // configuration channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CAP_BITS-1:0]  cfg_data,
    // storage ports
    output logic                 wr_en,
    output logic [ADDR_BITS-1:0] wr_addr,
    output logic [ID_BITS-1:0]   wr_data,
    output logic                 rd_en,
    output logic [ADDR_BITS-1:0] rd_addr,
    input  logic [ID_BITS-1:0]   rd_data
);

    localparam int CMP_BITS = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_POP_RD = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    function automatic logic [ADDR_BITS-1:0] ring_next(input logic [ADDR_BITS-1:0] p);
        ring_next = (p == ADDR_BITS'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    state_t                state_reg, state_next;
    logic [1:0]            op_reg, op_next;
    logic [ID_BITS-1:0]    id_reg, id_next;
    logic [ADDR_BITS-1:0]  pos_reg, pos_next;
    logic [CNT_BITS-1:0]   n_reg, n_next;
    logic                  pend_reg, pend_next;
    logic                  hit_reg, hit_next;
    logic [ADDR_BITS-1:0]  head_reg, head_next;
    logic [ADDR_BITS-1:0]  tail_reg, tail_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [CAP_BITS-1:0]   cap_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            status_reg, status_next;
    logic                  found_reg, found_next;
    logic [ID_BITS-1:0]    popped_reg, popped_next;
    logic [CNT_BITS-1:0]   occ_reg, occ_next;

    logic full;
    logic match;
    logic issue;
    logic load;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign found     = found_reg;
    assign popped_id = popped_reg;
    assign occupancy = occ_reg;

    // Full once count reaches capacity, clamped to the ring depth
    assign full = (CMP_BITS'(count_reg) >= CMP_BITS'(cap_reg))
                  || (count_reg == CNT_BITS'(DEPTH));

    // Scan pipeline: compare returning entry, issue next read if needed
    assign match = pend_reg && (rd_data == id_reg);
    assign issue = (state_reg == S_SCAN) && !match && (n_reg != count_reg);

    // Result register free or draining this cycle
    assign load = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);

    // Storage access
    assign rd_en   = issue || (state_reg == S_POP_RD);
    assign rd_addr = (state_reg == S_POP_RD) ? head_reg : pos_reg;
    assign wr_en   = load && (op_reg == OP_PUSH) && !full && !hit_reg;
    assign wr_addr = tail_reg;
    assign wr_data = id_reg;

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        pos_next       = pos_reg;
        n_next         = n_reg;
        pend_next      = pend_reg;
        hit_next       = hit_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        found_next     = found_reg;
        popped_next    = popped_reg;
        occ_next       = occ_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next   = operation;
                    id_next   = call_id;
                    pos_next  = head_reg;
                    n_next    = '0;
                    pend_next = 1'b0;
                    hit_next  = 1'b0;
                    if (operation == OP_PUSH && full)
                    begin
                        state_next = S_FINISH;
                    end
                    else if (operation inside {OP_PUSH, OP_LOOKUP})
                    begin
                        state_next = S_SCAN;
                    end
                    else if (operation == OP_POP && count_reg != '0)
                    begin
                        state_next = S_POP_RD;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end

            S_SCAN:
            begin
                hit_next  = hit_reg || match;
                pend_next = issue;
                if (issue)
                begin
                    pos_next = ring_next(pos_reg);
                    n_next   = n_reg + 1'b1;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_POP_RD:
            begin
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    found_next     = 1'b0;
                    popped_next    = '0;
                    case (op_reg)
                        OP_PUSH:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (hit_reg)
                            begin
                                status_next = ST_DUP;
                            end
                            else
                            begin
                                tail_next  = ring_next(tail_reg);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                popped_next = rd_data;
                                head_next   = ring_next(head_reg);
                                count_next  = count_reg - 1'b1;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            found_next = hit_reg;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                    occ_next   = count_next;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        id_reg     <= id_next;
        pos_reg    <= pos_next;
        n_reg      <= n_next;
        hit_reg    <= hit_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        popped_reg <= popped_next;
        occ_reg    <= occ_next;
    end

    // Checks
    `DFQ_ASSERT_NEVER(a_count_bound, count_reg > CNT_BITS'(DEPTH), "entry count above depth")
    `DFQ_ASSERT_NEVER(a_rd_wr_overlap, rd_en && wr_en, "read and write in the same cycle")
    `DFQ_ASSERT(a_count_at_finish, (count_reg != $past(count_reg)) |-> ($past(state_reg) == S_FINISH), "count moved outside finish")
    `DFQ_ASSERT(a_pend_in_scan, pend_reg |-> (state_reg == S_SCAN), "read pending outside scan")

endmodule
